// ===== sv/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the stereo sample ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

	// ring geometry; one slot always stays free
	localparam int RING_FRAMES = 8192;
	localparam int IDX_W       = $clog2(RING_FRAMES);
	localparam int USABLE      = RING_FRAMES - 1;

	localparam int SAMPLE_W = 16;
	localparam int FRAME_W  = 2 * SAMPLE_W;
	localparam int PCT_W    = 7;

	localparam int PCT_FULL        = 100;
	localparam int LOW_LEVEL_RESET = 20;

	// percent = queued * 100 / USABLE by reciprocal: estimate is exact or one low
	localparam int RECIP_SHIFT = IDX_W + 1;
	localparam int RECIP_MULT  = (PCT_FULL * (2 ** RECIP_SHIFT)) / USABLE;
	localparam int RECIP_W     = $clog2(RECIP_MULT + 1);

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [PCT_W-1:0]           pct_t;
	typedef logic [IDX_W-1:0]           idx_t;

endpackage

`default_nettype wire

// ===== sv/stereo_sample_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// stereo_sample_ring_buffer_core
// Stereo 16-bit frame FIFO with fill-level percent and running-low flag.
// ----------------------------------------------------------------------------
// A command word (push or pop) is taken on every cycle with start high; busy
// stays low, so one command per clock is sustained. Each command returns
// exactly one result word, marked by strobe for one cycle, in command order,
// after stage 1, stage 2 and the output register. The receiver cannot stall:
// a result shows for that single cycle and is gone. The stages hold the sample RAM's
// registered read (pop data) followed by the two-stage constant-divide of the
// fill percent. Of the RING_FRAMES slots one stays free, so at most
// RING_FRAMES-1 frames are queued. A push into a full ring is dropped and a
// pop from an empty ring returns silence; both report done_res low. Push
// results carry zero samples. occupancy_percent is the fill level after the
// command, queued*100/(RING_FRAMES-1) truncated. running_low is set when
// that percent is below low_level, written through the cfg port (reset 20);
// write it only while no result is pending. No clearing pass after reset:
// the sample RAM is never read where it was not written.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_sample_ring_buffer_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// command channel
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             cmd,
	input  wire srb_pkg::sample_t left_in,
	input  wire srb_pkg::sample_t right_in,
	// result channel
	output logic                  strobe,
	output srb_pkg::sample_t      left_out,
	output srb_pkg::sample_t      right_out,
	output logic                  done_res,
	output srb_pkg::pct_t         occupancy_percent,
	output logic                  running_low,
	// config write channel
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire srb_pkg::pct_t    cfg_data
);

	import srb_pkg::*;

	localparam int PROD_W = IDX_W + RECIP_W;   // queued * reciprocal
	localparam int P100_W = IDX_W + PCT_W;     // queued * 100
	localparam int CMP_W  = IDX_W + PCT_W + 1; // (estimate + 1) * USABLE

	// ------------------------------------------------------------------
	// Control state: indices, fill count, low level
	// ------------------------------------------------------------------
	idx_t wr_idx_q, rd_idx_q, count_q;
	pct_t low_level_q;

	logic accept, is_push, ring_full, ring_empty, push_ok, pop_ok;
	idx_t count_next;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign is_push   = (cmd == CMD_PUSH);

	assign ring_full  = (count_q == idx_t'(USABLE));
	assign ring_empty = (count_q == '0);
	assign push_ok    = accept && is_push && !ring_full;
	assign pop_ok     = accept && !is_push && !ring_empty;

	function automatic idx_t ring_next(input idx_t idx);
		return (idx == idx_t'(RING_FRAMES - 1)) ? '0 : idx + idx_t'(1);
	endfunction

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + idx_t'(1);
		end else if (pop_ok) begin
			count_next = count_q - idx_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			count_q     <= '0;
			low_level_q <= pct_t'(LOW_LEVEL_RESET);
		end else begin
			if (push_ok) begin
				wr_idx_q <= ring_next(wr_idx_q);
			end
			if (pop_ok) begin
				rd_idx_q <= ring_next(rd_idx_q);
			end
			count_q <= count_next;
			if (cfg_valid && cfg_ready) begin
				low_level_q <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample RAM: left in the low half, right in the high half.
	// Push and pop never share a cycle, and a pop only reads a slot whose
	// write landed at an earlier edge, so no forwarding is needed.
	// ------------------------------------------------------------------
	logic [FRAME_W-1:0] rdata;

	srb_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (RING_FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wr_idx_q),
		.wdata ({right_in, left_in}),
		.re    (pop_ok),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: command outcome and fill count after it; RAM read in flight
	// ------------------------------------------------------------------
	logic valid_s1, pop_ok_s1, done_s1;
	idx_t queued_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pop_ok_s1 <= pop_ok;
		done_s1   <= push_ok || pop_ok;
		queued_s1 <= count_next;
	end

	// ------------------------------------------------------------------
	// Stage 2: capture pop data, reciprocal estimate and queued * 100
	// ------------------------------------------------------------------
	logic              valid_s2, done_s2;
	sample_t           left_s2, right_s2;
	pct_t              est_s2;
	logic [P100_W-1:0] prod100_s2;
	logic [PROD_W-1:0] recip_prod;

	assign recip_prod = PROD_W'(queued_s1) * PROD_W'(RECIP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		done_s2    <= done_s1;
		// push and empty pop give silence
		left_s2    <= pop_ok_s1 ? rdata[SAMPLE_W-1:0] : '0;
		right_s2   <= pop_ok_s1 ? rdata[FRAME_W-1:SAMPLE_W] : '0;
		est_s2     <= pct_t'(recip_prod >> RECIP_SHIFT);
		prod100_s2 <= P100_W'(queued_s1) * P100_W'(PCT_FULL);
	end

	// ------------------------------------------------------------------
	// Stage 3: correct estimate by one, clamp, low-level compare
	// ------------------------------------------------------------------
	logic [CMP_W-1:0] est_inc, bound;
	pct_t             pct_fix, pct_next;

	always_comb begin
		est_inc  = CMP_W'(est_s2) + CMP_W'(1);
		bound    = est_inc * CMP_W'(USABLE);
		pct_fix  = (bound <= CMP_W'(prod100_s2)) ? est_s2 + pct_t'(1) : est_s2;
		pct_next = (pct_fix > pct_t'(PCT_FULL)) ? pct_t'(PCT_FULL) : pct_fix;
	end

	logic    strobe_q, done_q, low_q;
	sample_t left_q, right_q;
	pct_t    pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		done_q  <= done_s2;
		left_q  <= left_s2;
		right_q <= right_s2;
		pct_q   <= pct_next;
		low_q   <= (pct_next < low_level_q);
	end

	assign strobe            = strobe_q;
	assign left_out          = left_q;
	assign right_out         = right_q;
	assign done_res          = done_q;
	assign occupancy_percent = pct_q;
	assign running_low       = low_q;

endmodule

`default_nettype wire

// ===== sv/srb_ram.sv =====
// ----------------------------------------------------------------------------
// srb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/srb_checker.sv =====
// ----------------------------------------------------------------------------
// srb_checker
// Port-level checks of the ring buffer core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             cmd,
	input wire srb_pkg::sample_t left_in,
	input wire srb_pkg::sample_t right_in,
	input wire logic             strobe,
	input wire srb_pkg::sample_t left_out,
	input wire srb_pkg::sample_t right_out,
	input wire logic             done_res,
	input wire srb_pkg::pct_t    occupancy_percent,
	input wire logic             running_low,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire srb_pkg::pct_t    cfg_data
);

	import srb_pkg::*;

	// every command yields its result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 strobe)
		else $error("no result three cycles after command");

	// no result without a command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 3))
		else $error("result without command");

	// push results carry no samples
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(cmd, 3) == CMD_PUSH) |-> (left_out == '0 && right_out == '0))
		else $error("push result carries samples");

	// dropped push or failed pop is silence
	a_underrun_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !done_res) |-> (left_out == '0 && right_out == '0))
		else $error("dropped or underrun result carries samples");

	// fill level never exceeds full scale
	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (occupancy_percent <= pct_t'(PCT_FULL)))
		else $error("occupancy percent above full scale");

endmodule

bind stereo_sample_ring_buffer_core srb_checker u_srb_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo sample ring buffer core. Drives push and
// pop command words with random idle gaps and checks every result word
// against a cycle-free predictor of the ring, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import srb_pkg::*;

	// result delay through the core pipeline; pad a little on drains
	localparam int LATENCY     = 3;
	// worst legal run is roughly 1k words with idle gaps
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_MAX    = 10;

	// one result word as the core reports it
	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    done;
		pct_t    pct;
		logic    low;
	} ring_reply_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    cmd;
	sample_t left_in;
	sample_t right_in;
	logic    strobe;
	sample_t left_out;
	sample_t right_out;
	logic    done_res;
	pct_t    occupancy_percent;
	logic    running_low;
	logic    cfg_valid;
	logic    cfg_ready;
	pct_t    cfg_data;

	// predictor state: its own copy of the ring and the low-level register
	logic [FRAME_W-1:0] frame_mem [RING_FRAMES];
	idx_t               wr_ptr;
	idx_t               rd_ptr;
	pct_t               low_level;

	ring_reply_t ring_replies [$];   // predicted result words, oldest first
	int          mismatches;
	bit          idle_on;            // sender may insert idle bursts

	stereo_sample_ring_buffer_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.cmd               (cmd),
		.left_in           (left_in),
		.right_in          (right_in),
		.strobe            (strobe),
		.left_out          (left_out),
		.right_out         (right_out),
		.done_res          (done_res),
		.occupancy_percent (occupancy_percent),
		.running_low       (running_low),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// frames held in the ring; ring size is a power of two, so 13-bit wrap does it
	function automatic idx_t frames_queued();
		return wr_ptr - rd_ptr;
	endfunction

	// apply one command to the predicted ring and return its result word
	function automatic ring_reply_t ring_apply(logic op, sample_t l, sample_t r);
		ring_reply_t rep;
		idx_t        nxt;
		int          pct;
		rep = '0;
		if (op == CMD_PUSH) begin
			nxt = wr_ptr + 1'b1;
			// one slot always stays free: next == read means full, frame dropped
			if (nxt != rd_ptr) begin
				frame_mem[wr_ptr] = {r, l};
				wr_ptr = nxt;
				rep.done = 1'b1;
			end
		end else if (rd_ptr != wr_ptr) begin
			rep.left  = frame_mem[rd_ptr][SAMPLE_W-1:0];
			rep.right = frame_mem[rd_ptr][FRAME_W-1:SAMPLE_W];
			rd_ptr = rd_ptr + 1'b1;
			rep.done = 1'b1;
		end
		// empty pop and any push leave the samples at zero (silence)
		pct = (int'(frames_queued()) * PCT_FULL) / USABLE;
		if (pct > PCT_FULL)
			pct = PCT_FULL;
		rep.pct = pct_t'(pct);
		// compared as written, so a level above 100 keeps the flag set
		rep.low = (rep.pct < low_level);
		return rep;
	endfunction

	// random sample, with the signed extremes showing up now and then
	function automatic sample_t rnd_sample();
		case ($urandom_range(0, 11))
			0:       return sample_t'(16'h8000);
			1:       return sample_t'(16'h7fff);
			2:       return sample_t'(16'h0000);
			3:       return sample_t'(16'hffff);
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display("%s", what);
	endtask

	// Prediction and checking share one clocked process: a command word is
	// taken at the edge where start is high and busy low, and every strobe
	// word is matched against the oldest prediction.
	always @(posedge clk) begin : reply_check
		ring_reply_t want;
		ring_reply_t got;
		if (start && !busy)
			ring_replies.push_back(ring_apply(cmd, left_in, right_in));
		if (strobe) begin
			got = {left_out, right_out, done_res, occupancy_percent, running_low};
			if (ring_replies.size() == 0) begin
				flag_mismatch($sformatf(
					"unexpected result word: L=%0d R=%0d done=%0b pct=%0d low=%0b",
					got.left, got.right, got.done, got.pct, got.low));
			end else begin
				want = ring_replies.pop_front();
				if (got.left !== want.left || got.right !== want.right ||
				    got.done !== want.done || got.pct !== want.pct ||
				    got.low !== want.low)
					flag_mismatch($sformatf({
						"mismatch: exp L=%0d R=%0d done=%0b pct=%0d low=%0b, ",
						"got L=%0d R=%0d done=%0b pct=%0d low=%0b"},
						want.left, want.right, want.done, want.pct, want.low,
						got.left, got.right, got.done, got.pct, got.low));
			end
		end
	end

	// Send one command word. An optional idle burst goes first, with noise on
	// the payload while start is low. start is left high on return so that a
	// following word goes back to back; settle() drops it.
	task automatic send_word(logic op, sample_t l, sample_t r);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (gap) begin
				cmd      <= 1'($urandom());
				left_in  <= sample_t'($urandom());
				right_in <= sample_t'($urandom());
				@(posedge clk);
			end
		end
		start    <= 1'b1;
		cmd      <= op;
		left_in  <= l;
		right_in <= r;
		do @(posedge clk); while (busy);
	endtask

	// stop sending, wait for every predicted word, then let the pipe run dry
	task automatic settle();
		start <= 1'b0;
		while (ring_replies.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// register write, only ever done with the core idle
	task automatic write_low_level(pct_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		low_level = v;
	endtask

	// Directed: underrun on an empty ring, signed extremes through the ring,
	// pushes reporting zero samples, the reset low level, then levels 0, 127
	// (above 100) and 1.
	task automatic test_directed();
		send_word(CMD_POP, sample_t'(16'h1234), sample_t'(16'h4321));
		send_word(CMD_PUSH, sample_t'(16'h8000), sample_t'(16'h7fff));
		send_word(CMD_PUSH, sample_t'(16'h7fff), sample_t'(16'h8000));
		send_word(CMD_PUSH, sample_t'(16'h0000), sample_t'(16'hffff));
		send_word(CMD_PUSH, sample_t'(16'hffff), sample_t'(16'h0000));
		send_word(CMD_PUSH, sample_t'(16'h5555), sample_t'(16'haaaa));
		repeat (3) send_word(CMD_POP, sample_t'(16'hffff), sample_t'(16'hffff));
		send_word(CMD_PUSH, sample_t'(16'haaaa), sample_t'(16'h5555));
		repeat (4) send_word(CMD_POP, sample_t'(16'h0000), sample_t'(16'h0000));
		write_low_level(pct_t'(0));
		send_word(CMD_PUSH, rnd_sample(), rnd_sample());
		repeat (2) send_word(CMD_POP, rnd_sample(), rnd_sample());
		write_low_level(pct_t'(127));
		send_word(CMD_PUSH, rnd_sample(), rnd_sample());
		send_word(CMD_POP, rnd_sample(), rnd_sample());
		write_low_level(pct_t'(1));
		repeat (2) send_word(CMD_PUSH, rnd_sample(), rnd_sample());
		repeat (2) send_word(CMD_POP, rnd_sample(), rnd_sample());
	endtask

	// Deep fill: enough pushes to walk the percent up through 1 and 2 with
	// the low level crossing, a level above 100, then drain to empty and one
	// underrun.
	task automatic test_deep_fill();
		int n;
		write_low_level(pct_t'(2));
		repeat (200) send_word(CMD_PUSH, rnd_sample(), rnd_sample());
		write_low_level(pct_t'(101));
		send_word(CMD_PUSH, rnd_sample(), rnd_sample());
		send_word(CMD_POP, rnd_sample(), rnd_sample());
		write_low_level(pct_t'(1));
		n = int'(frames_queued()) + 1;
		repeat (n) send_word(CMD_POP, rnd_sample(), rnd_sample());
	endtask

	// Random push/pop mix in phases with their own push bias and low level.
	// Once mid-stream the sender holds off until all results are back; the
	// last phase runs with no idle gaps.
	task automatic test_random_traffic();
		int   push_bias [6];
		pct_t lvl;
		logic op;
		push_bias = '{75, 60, 50, 40, 70, 25};
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       lvl = pct_t'(3);
				2:       lvl = pct_t'(0);
				3:       lvl = pct_t'(PCT_FULL);
				4:       lvl = pct_t'($urandom_range(0, 127));
				default: lvl = pct_t'($urandom_range(1, 8));
			endcase
			write_low_level(lvl);
			if (ph == 5)
				idle_on = 1'b0;
			for (int i = 0; i < 90; i++) begin
				if (ph == 2 && i == 45)
					settle();
				op = ($urandom_range(0, 99) < push_bias[ph]) ? CMD_PUSH : CMD_POP;
				send_word(op, rnd_sample(), rnd_sample());
			end
		end
	endtask

	// run watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= CMD_PUSH;
		left_in   <= '0;
		right_in  <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		idle_on    = 1'b1;
		mismatches = 0;
		wr_ptr     = '0;
		rd_ptr     = '0;
		low_level  = pct_t'(LOW_LEVEL_RESET);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_deep_fill();
		test_random_traffic();
		settle();

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
